// ----- sv/sdadc_pkg.sv -----
// Shared types and constants for the sigma-delta converter read controller.
// No dependencies; used by every module of the block.

package sdadc_pkg;

	// input item opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_DONE  = 2'd1;
	localparam logic [1:0] OP_DRDY  = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_CLOCK    = 3'd0;
	localparam logic [2:0] REG_SETUP    = 3'd1;
	localparam logic [2:0] REG_RST_CNT  = 3'd2;
	localparam logic [2:0] REG_DELAY    = 3'd3;
	localparam logic [2:0] REG_FSCALE   = 3'd4;
	localparam logic [2:0] REG_WIN_LOW  = 3'd5;
	localparam logic [2:0] REG_WIN_HIGH = 3'd6;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 18;
	localparam int VAL_W     = 18;
	localparam int CODE_W    = 16;
	localparam int PROD_W    = CODE_W + VAL_W;
	localparam int OUT_W     = 48;

	// register reset values
	localparam logic [7:0]       RST_CLOCK    = 8'h0F;
	localparam logic [7:0]       RST_SETUP    = 8'h4C;
	localparam logic [7:0]       RST_RST_CNT  = 8'd151;
	localparam logic [7:0]       RST_DELAY    = 8'd1;
	localparam logic [VAL_W-1:0] RST_FSCALE   = 18'd122500;
	localparam logic [VAL_W-1:0] RST_WIN_LOW  = 18'd8200;
	localparam logic [VAL_W-1:0] RST_WIN_HIGH = 18'd8500;

	// converter command bytes
	localparam logic [7:0] BYTE_FILL     = 8'hFF;
	localparam logic [7:0] CMD_CLOCK_REG = 8'h20;
	localparam logic [7:0] CMD_SETUP_REG = 8'h10;
	localparam logic [7:0] CMD_READ      = 8'h38;
	localparam logic [7:0] CFG_LAST      = 8'd3;

	localparam logic [15:0] DIV_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0]       clock_val;
		logic [7:0]       setup_val;
		logic [7:0]       reset_bytes;
		logic [7:0]       delay_ticks;
		logic [VAL_W-1:0] full_scale;
		logic [VAL_W-1:0] window_low;
		logic [VAL_W-1:0] window_high;
	} cfg_t;

	typedef struct packed {
		logic              spi_start;
		logic [7:0]        tx_byte;
		logic              select_active;
		logic              busy;
		logic              sample_valid;
		logic              sample_channel;
		logic [CODE_W-1:0] sample_code;
	} step_t;

	typedef enum logic [8:0] {
		PH_IDLE    = 9'b000000001,
		PH_RESET   = 9'b000000010,
		PH_WAIT1   = 9'b000000100,
		PH_CFG     = 9'b000001000,
		PH_WAIT2   = 9'b000010000,
		PH_CMD     = 9'b000100000,
		PH_DRDY    = 9'b001000000,
		PH_READ_HI = 9'b010000000,
		PH_READ_LO = 9'b100000000
	} phase_t;

endpackage

// ----- sv/sdadc_cfg_regs.sv -----
// Configuration register file of the converter read controller.
// Depends on sdadc_pkg.

module sdadc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [sdadc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [sdadc_pkg::CFG_DAT_W-1:0] wr_data,
	output sdadc_pkg::cfg_t                cfg
);

	sdadc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_val   <= sdadc_pkg::RST_CLOCK;
			cfg_q.setup_val   <= sdadc_pkg::RST_SETUP;
			cfg_q.reset_bytes <= sdadc_pkg::RST_RST_CNT;
			cfg_q.delay_ticks <= sdadc_pkg::RST_DELAY;
			cfg_q.full_scale  <= sdadc_pkg::RST_FSCALE;
			cfg_q.window_low  <= sdadc_pkg::RST_WIN_LOW;
			cfg_q.window_high <= sdadc_pkg::RST_WIN_HIGH;
		end else if (wr_en) begin
			case (wr_index)
				sdadc_pkg::REG_CLOCK:    cfg_q.clock_val   <= wr_data[7:0];
				sdadc_pkg::REG_SETUP:    cfg_q.setup_val   <= wr_data[7:0];
				sdadc_pkg::REG_RST_CNT:  cfg_q.reset_bytes <= wr_data[7:0];
				sdadc_pkg::REG_DELAY:    cfg_q.delay_ticks <= wr_data[7:0];
				sdadc_pkg::REG_FSCALE:   cfg_q.full_scale  <= wr_data;
				sdadc_pkg::REG_WIN_LOW:  cfg_q.window_low  <= wr_data;
				sdadc_pkg::REG_WIN_HIGH: cfg_q.window_high <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/sdadc_seq.sv -----
// Read sequencer: reset run, register setup, read command, data-ready wait
// and two-byte readout. One event per accepted item. Depends on sdadc_pkg.

module sdadc_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [1:0]      opcode,
	input  logic            channel_index,
	input  logic [7:0]      rx_byte,
	input  logic            drdy_level,
	input  sdadc_pkg::cfg_t cfg,
	output sdadc_pkg::step_t step
);

	sdadc_pkg::phase_t phase_q, phase_d;
	logic [7:0] byte_cnt_q, byte_cnt_d;
	logic [7:0] tick_cnt_q, tick_cnt_d;
	logic       chan_q, chan_d;
	logic [7:0] high_byte_q, high_byte_d;

	logic [7:0] tick_inc;
	logic [7:0] limit;
	logic       wait_hit;
	logic [7:0] cfg_next;
	logic [7:0] cfg_byte;

	assign tick_inc = tick_cnt_q + 8'd1;
	assign limit    = (cfg.delay_ticks == 8'd0) ? 8'd1 : cfg.delay_ticks;
	assign wait_hit = (tick_inc >= limit);
	assign cfg_next = byte_cnt_q + 8'd1;

	always_comb begin
		case (cfg_next[1:0])
			2'd0:    cfg_byte = sdadc_pkg::CMD_CLOCK_REG | {7'd0, chan_q};
			2'd1:    cfg_byte = cfg.clock_val;
			2'd2:    cfg_byte = sdadc_pkg::CMD_SETUP_REG | {7'd0, chan_q};
			default: cfg_byte = cfg.setup_val;
		endcase
	end

	always_comb begin
		phase_d     = phase_q;
		byte_cnt_d  = byte_cnt_q;
		tick_cnt_d  = tick_cnt_q;
		chan_d      = chan_q;
		high_byte_d = high_byte_q;
		step        = '0;
		case (phase_q)
			sdadc_pkg::PH_IDLE: begin
				if (opcode == sdadc_pkg::OP_START) begin
					chan_d             = channel_index;
					byte_cnt_d         = 8'd1;
					tick_cnt_d         = 8'd0;
					phase_d            = sdadc_pkg::PH_RESET;
					step.spi_start     = 1'b1;
					step.tx_byte       = sdadc_pkg::BYTE_FILL;
					step.select_active = 1'b1;
				end
			end
			sdadc_pkg::PH_RESET: begin
				if (opcode == sdadc_pkg::OP_DONE) begin
					if (byte_cnt_q >= cfg.reset_bytes) begin
						phase_d    = sdadc_pkg::PH_WAIT1;
						tick_cnt_d = 8'd0;
					end else begin
						byte_cnt_d         = byte_cnt_q + 8'd1;
						step.spi_start     = 1'b1;
						step.tx_byte       = sdadc_pkg::BYTE_FILL;
						step.select_active = 1'b1;
					end
				end else begin
					step.select_active = 1'b1;
				end
			end
			sdadc_pkg::PH_WAIT1: begin
				if (opcode == sdadc_pkg::OP_TICK) begin
					tick_cnt_d = tick_inc;
					if (wait_hit) begin
						phase_d            = sdadc_pkg::PH_CFG;
						byte_cnt_d         = 8'd0;
						step.spi_start     = 1'b1;
						step.tx_byte       = sdadc_pkg::CMD_CLOCK_REG | {7'd0, chan_q};
						step.select_active = 1'b1;
					end
				end
			end
			sdadc_pkg::PH_CFG: begin
				if (opcode == sdadc_pkg::OP_DONE) begin
					if (byte_cnt_q >= sdadc_pkg::CFG_LAST) begin
						phase_d    = sdadc_pkg::PH_WAIT2;
						tick_cnt_d = 8'd0;
					end else begin
						byte_cnt_d         = cfg_next;
						step.spi_start     = 1'b1;
						step.tx_byte       = cfg_byte;
						step.select_active = 1'b1;
					end
				end else begin
					step.select_active = 1'b1;
				end
			end
			sdadc_pkg::PH_WAIT2: begin
				if (opcode == sdadc_pkg::OP_TICK) begin
					tick_cnt_d = tick_inc;
					if (wait_hit) begin
						phase_d            = sdadc_pkg::PH_CMD;
						step.spi_start     = 1'b1;
						step.tx_byte       = sdadc_pkg::CMD_READ | {7'd0, chan_q};
						step.select_active = 1'b1;
					end
				end
			end
			sdadc_pkg::PH_CMD: begin
				if (opcode == sdadc_pkg::OP_DONE)
					phase_d = sdadc_pkg::PH_DRDY;
				else
					step.select_active = 1'b1;
			end
			sdadc_pkg::PH_DRDY: begin
				// data-ready is active low
				if (opcode == sdadc_pkg::OP_DRDY && !drdy_level) begin
					phase_d            = sdadc_pkg::PH_READ_HI;
					step.spi_start     = 1'b1;
					step.tx_byte       = sdadc_pkg::BYTE_FILL;
					step.select_active = 1'b1;
				end
			end
			sdadc_pkg::PH_READ_HI: begin
				step.select_active = 1'b1;
				if (opcode == sdadc_pkg::OP_DONE) begin
					high_byte_d    = rx_byte;
					phase_d        = sdadc_pkg::PH_READ_LO;
					step.spi_start = 1'b1;
					step.tx_byte   = sdadc_pkg::BYTE_FILL;
				end
			end
			sdadc_pkg::PH_READ_LO: begin
				if (opcode == sdadc_pkg::OP_DONE) begin
					step.sample_code    = {high_byte_q, rx_byte};
					step.sample_valid   = 1'b1;
					step.sample_channel = chan_q;
					phase_d             = sdadc_pkg::PH_IDLE;
				end else begin
					step.select_active = 1'b1;
				end
			end
			default: phase_d = sdadc_pkg::PH_IDLE;
		endcase
		step.busy = (phase_d != sdadc_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sdadc_pkg::PH_IDLE;
			byte_cnt_q  <= 8'd0;
			tick_cnt_q  <= 8'd0;
			chan_q      <= 1'b0;
			high_byte_q <= 8'd0;
		end else if (accept) begin
			phase_q     <= phase_d;
			byte_cnt_q  <= byte_cnt_d;
			tick_cnt_q  <= tick_cnt_d;
			chan_q      <= chan_d;
			high_byte_q <= high_byte_d;
		end
	end

endmodule

// ----- sv/sdadc_mul.sv -----
// First pipeline stage: holds the step result and the code times full-scale
// product. Depends on sdadc_pkg.

module sdadc_mul (
	input  logic                              clk,
	input  logic                              en,
	input  sdadc_pkg::step_t                  step,
	input  logic [sdadc_pkg::VAL_W-1:0]       full_scale,
	output sdadc_pkg::step_t                  step_s1,
	output logic [sdadc_pkg::PROD_W-1:0]      prod_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			step_s1 <= step;
			prod_s1 <= sdadc_pkg::PROD_W'(step.sample_code) *
			           sdadc_pkg::PROD_W'(full_scale);
		end
	end

endmodule

// ----- sv/sdadc_out.sv -----
// Second pipeline stage: divide by 65535, window check and the packed
// result register. Depends on sdadc_pkg.

module sdadc_out (
	input  logic                              clk,
	input  logic                              en,
	input  sdadc_pkg::step_t                  step_s1,
	input  logic [sdadc_pkg::PROD_W-1:0]      prod_s1,
	input  logic [sdadc_pkg::VAL_W-1:0]       window_low,
	input  logic [sdadc_pkg::VAL_W-1:0]       window_high,
	output logic [sdadc_pkg::OUT_W-1:0]       tdata_s2
);

	// p = 65535*hi + (hi + lo); fold the high part back twice,
	// then one compare finishes the remainder.
	logic [sdadc_pkg::VAL_W-1:0] q_hi;
	logic [15:0]                 q_lo;
	logic [18:0]                 fold1;
	logic [2:0]                  fold1_hi;
	logic [16:0]                 fold2;
	logic                        carry;
	logic [19:0]                 quot;
	logic [sdadc_pkg::VAL_W-1:0] scaled;
	logic                        in_win;

	assign q_hi     = prod_s1[sdadc_pkg::PROD_W-1:16];
	assign q_lo     = prod_s1[15:0];
	assign fold1    = 19'(q_hi) + 19'(q_lo);
	assign fold1_hi = fold1[18:16];
	assign fold2    = 17'(fold1_hi) + 17'(fold1[15:0]);
	assign carry    = (fold2 >= 17'(sdadc_pkg::DIV_MAX));
	assign quot     = 20'(q_hi) + 20'(fold1_hi) + 20'(carry);
	assign scaled   = quot[sdadc_pkg::VAL_W-1:0];
	assign in_win   = step_s1.sample_valid &&
	                  (scaled >= window_low) && (scaled <= window_high);

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_s2 <= {in_win, scaled, step_s1.sample_code, step_s1.sample_channel,
			             step_s1.sample_valid, step_s1.busy, step_s1.select_active,
			             step_s1.tx_byte, step_s1.spi_start};
		end
	end

endmodule

// ----- sv/sigma_delta_adc_spi_reader_unit.sv -----
// Top level of the sigma-delta converter SPI read controller.
// Depends on sdadc_pkg, sdadc_cfg_regs, sdadc_seq, sdadc_mul, sdadc_out.
//
// Usage:
//   s_* carries events: start read, SPI byte done, data-ready sample and
//   millisecond tick. Every accepted item yields exactly one result item on
//   m_*, which tells the SPI engine whether to start a byte exchange, the
//   chip-select level, busy, and on the last byte of a read the 16-bit code,
//   the scaled value and the window flag.
//   cfg_* writes one configuration register per handshake; cfg_ready is
//   always high. Write only while no read sequence is running.
// Timing:
//   The sequencer updates on the accepting edge; the scaling multiply is
//   registered in the first stage and the divide/window logic feeds the
//   output register, so a result passes through both stage registers.
//   Throughput is one item per cycle while m_tready stays high.
// Reset and stall:
//   arst_n puts the sequencer in idle and the configuration registers at their defaults.
//   While m_tready is low the output register holds; the first stage still
//   takes one more item, then s_tready drops until the result is taken.

module sigma_delta_adc_spi_reader_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // channel_index[0], rx_byte[8:1], drdy_level[9], zero pad
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// spi_start[0], tx_byte[8:1], select_active[9], busy_res[10], sample_valid[11],
	// sample_channel[12], sample_code[28:13], scaled_value[46:29], in_window[47]
	output logic [47:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data
);

	sdadc_pkg::cfg_t                  cfg;
	sdadc_pkg::step_t                 step;
	sdadc_pkg::step_t                 step_s1;
	logic [sdadc_pkg::PROD_W-1:0]     prod_s1;
	logic                             v_s1, v_s2;
	logic                             en1, en2, accept;

	assign en2       = !v_s2 || m_tready;
	assign en1       = !v_s1 || en2;
	assign s_tready  = en1;
	assign accept    = s_tvalid && en1;
	assign m_tvalid  = v_s2;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= accept;
			if (en2)
				v_s2 <= v_s1;
		end
	end

	sdadc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	sdadc_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.opcode        (s_tuser),
		.channel_index (s_tdata[0]),
		.rx_byte       (s_tdata[8:1]),
		.drdy_level    (s_tdata[9]),
		.cfg           (cfg),
		.step          (step)
	);

	sdadc_mul u_mul (
		.clk        (clk),
		.en         (en1),
		.step       (step),
		.full_scale (cfg.full_scale),
		.step_s1    (step_s1),
		.prod_s1    (prod_s1)
	);

	sdadc_out u_out (
		.clk         (clk),
		.en          (en2),
		.step_s1     (step_s1),
		.prod_s1     (prod_s1),
		.window_low  (cfg.window_low),
		.window_high (cfg.window_high),
		.tdata_s2    (m_tdata)
	);

	// a completed read always ends the sequence
	a_sample_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[11] |-> !m_tdata[10])
		else $error("sample reported while still busy");

	a_window_needs_sample: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[47] |-> m_tdata[11])
		else $error("in_window without a sample");

	a_tx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[8:1] == 8'd0))
		else $error("tx byte set without an exchange start");

	// input side only backs up when both stages are full and stalled
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && !m_tready))
		else $error("input stalled with room in the pipeline");

	a_stage2_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && en2 |=> v_s2)
		else $error("first stage item lost on its way to the output");

endmodule
